FILE: rtl/rtl_text_line_reorder_assert.svh
// Assertion macros shared by the line reorder checker.
`ifndef RTL_TEXT_LINE_REORDER_ASSERT_SVH
`define RTL_TEXT_LINE_REORDER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define TLR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlr assertion failed");

// The antecedent implies the consequent in the next cycle.
`define TLR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlr assertion failed");

`endif

FILE: rtl/tlr_pkg.sv
// Package with shared types, constants and a helper function for the line reorder block.
`timescale 1ns / 1ps

package tlr_pkg;

   localparam int MAX_LEN_DEF = 64;

   localparam logic [7:0] HEB_LEAD  = 8'hD7;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_UP_A  = 8'h41;
   localparam logic [7:0] CHR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHR_LO_A  = 8'h61;
   localparam logic [7:0] CHR_LO_Z  = 8'h7A;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FIND,
      ST_LOOK,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic find;
      logic look;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic acc_last;
      logic out_free;
      logic at_end;
      logic tok_zero;
   } sts_type;

   function automatic logic is_alnum(input logic [7:0] b);
      is_alnum = ((b >= CHR_0) && (b <= CHR_9)) ||
                 ((b >= CHR_UP_A) && (b <= CHR_UP_Z)) ||
                 ((b >= CHR_LO_A) && (b <= CHR_LO_Z));
   endfunction

endpackage

FILE: rtl/tlr_req_if.sv
// Handshake interface for the incoming byte stream.
`timescale 1ns / 1ps

interface tlr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/tlr_rsp_if.sv
// Handshake interface for the reordered byte stream.
`timescale 1ns / 1ps

interface tlr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       truncated;

   modport source (output valid, output out_byte, output out_last, output truncated,
                   input ready);
   modport sink (input valid, input out_byte, input out_last, input truncated,
                 output ready);
endinterface

FILE: rtl/tlr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tlr_ctrl.sv
// Controller state machine that sequences loading, token lookup and emission.
`timescale 1ns / 1ps

module tlr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  tlr_pkg::sts_type sts,
   output tlr_pkg::cmd_type cmd
);

   tlr_pkg::state_type state_ff;
   tlr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlr_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tlr_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.acc_last) begin
               state_in = tlr_pkg::ST_FIND;
            end
         end
         tlr_pkg::ST_FIND: begin
            cmd.find = 1'b1;
            state_in = tlr_pkg::ST_LOOK;
         end
         tlr_pkg::ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = tlr_pkg::ST_SEND;
         end
         tlr_pkg::ST_SEND: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.at_end) begin
                  state_in = sts.tok_zero ? tlr_pkg::ST_LOAD : tlr_pkg::ST_LOOK;
               end
            end
         end
      endcase
   end

endmodule

FILE: rtl/tlr_dp.sv
// Datapath: line buffer, token start tracking, read pointers and output register.
`timescale 1ns / 1ps

module tlr_dp #(
   parameter int MAX_LEN = tlr_pkg::MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   tlr_req_if.sink          req,
   tlr_rsp_if.source        rsp,
   input  tlr_pkg::cmd_type cmd,
   output tlr_pkg::sts_type sts
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int WW = 8 + AW;

   // Control state.
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          lead_ff, lead_in;
   logic          aln_ff, aln_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Pointers and payload.
   logic [AW-1:0] cur_start_ff, cur_start_in;
   logic [AW-1:0] tok_start_ff, tok_start_in;
   logic [AW-1:0] tok_end_ff, tok_end_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   logic          trunc_ff, trunc_in;

   logic          accept, full, store, alnum_b, cont, line_end;
   logic          at_end, tok_zero;
   logic [AW-1:0] start_idx;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] rd_data;
   logic [7:0]    rd_byte;
   logic [AW-1:0] rd_start;

   assign accept    = cmd.load & req.valid;
   assign full      = (count_ff == CW'(MAX_LEN));
   assign store     = accept & ~full;
   assign alnum_b   = tlr_pkg::is_alnum(req.in_byte);
   // A byte continues the open token after a Hebrew lead byte or inside a letter/digit run.
   assign cont      = lead_ff | (alnum_b & aln_ff);
   assign start_idx = cont ? cur_start_ff : count_ff[AW-1:0];

   assign rd_byte   = rd_data[7:0];
   assign rd_start  = rd_data[8 +: AW];

   assign at_end    = (ptr_ff == tok_end_ff);
   assign tok_zero  = (tok_start_ff == '0);
   assign line_end  = cmd.emit & at_end & tok_zero;

   assign req.ready     = cmd.load;
   assign sts.acc_last  = req.valid & req.in_last;
   assign sts.out_free  = ~rsp_valid_ff | rsp.ready;
   assign sts.at_end    = at_end;
   assign sts.tok_zero  = tok_zero;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = tok_end_ff;
      priority if (cmd.find) begin
         rd_en   = 1'b1;
         rd_addr = tok_end_ff;
      end else if (cmd.look) begin
         rd_en   = 1'b1;
         rd_addr = rd_start;
      end else if (cmd.emit && !at_end) begin
         rd_en   = 1'b1;
         rd_addr = ptr_ff + 1'b1;
      end else if (cmd.emit && !tok_zero) begin
         rd_en   = 1'b1;
         rd_addr = tok_start_ff - 1'b1;
      end else begin
         rd_en   = 1'b0;
         rd_addr = tok_end_ff;
      end
   end

   tlr_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_LEN)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({start_idx, req.in_byte}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lead_in      = lead_ff;
      aln_in       = aln_ff;
      cur_start_in = cur_start_ff;
      tok_start_in = tok_start_ff;
      tok_end_in   = tok_end_ff;
      ptr_in       = ptr_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;

      if (accept) begin
         tok_end_in = full ? AW'(MAX_LEN - 1) : count_ff[AW-1:0];
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in     = count_ff + 1'b1;
            cur_start_in = start_idx;
            lead_in      = ~cont & (req.in_byte == tlr_pkg::HEB_LEAD);
            aln_in       = alnum_b & ~lead_ff;
         end
      end

      if (cmd.look) begin
         tok_start_in = rd_start;
         ptr_in       = rd_start;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = rd_byte;
         out_last_in  = at_end & tok_zero;
         trunc_in     = ovf_ff;
         if (!at_end) begin
            ptr_in = ptr_ff + 1'b1;
         end else begin
            tok_end_in = tok_start_ff - 1'b1;
         end
      end

      if (line_end) begin
         count_in = '0;
         ovf_in   = 1'b0;
         lead_in  = 1'b0;
         aln_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         lead_ff      <= 1'b0;
         aln_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         lead_ff      <= lead_in;
         aln_ff       <= aln_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_start_ff <= cur_start_in;
      tok_start_ff <= tok_start_in;
      tok_end_ff   <= tok_end_in;
      ptr_ff       <= ptr_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      trunc_ff     <= trunc_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_byte  = out_byte_ff;
   assign rsp.out_last  = out_last_ff;
   assign rsp.truncated = trunc_ff;

endmodule

FILE: rtl/rtl_text_line_reorder.sv
// Top level of the text line reorder block: controller plus datapath.
`timescale 1ns / 1ps
// Loading accepts one byte per cycle; req_bus.ready stays high until the final byte.
// After the final transaction the controller steps through find, look up and send,
// where result bytes are registered one per cycle while the receiver keeps up; each
// further token first passes through look up for its start, since the line buffer has one read port.
// Reset (synchronous, active high) clears the state machine, byte count, overflow flag
// and output valid; the line buffer itself is not cleared.

module rtl_text_line_reorder #(
   parameter int MAX_LEN = tlr_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tlr_req_if.sink   req_bus,
   tlr_rsp_if.source rsp_bus
);

   // Commands from the controller and status back from the datapath.
   tlr_pkg::cmd_type cmd;
   tlr_pkg::sts_type sts;

   // The controller walks through four phases: load bytes, fetch the start of the
   // last token, look up each token start, and send bytes of the current token.
   tlr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath stores each byte together with the index of its token's first
   // byte, worked out while the line streams in. Emission reads the final byte of
   // a token, jumps to its start, reads forward to its end, then moves to the byte
   // just before that start, so tokens come out in reverse order.
   tlr_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

FILE: rtl/tlr_checker.sv
// Port-level checker for the line reorder block, bound to the top level.
`timescale 1ns / 1ps
`include "rtl_text_line_reorder_assert.svh"

module tlr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last,
   input logic       rsp_trunc
);

   logic req_xfer, rsp_stall;

   assign req_xfer  = req_valid & req_ready;
   assign rsp_stall = rsp_valid & ~rsp_ready;

   `TLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable({rsp_byte, rsp_last, rsp_trunc}))
   `TLR_ASSERT_NEXT(a_busy_after_last, clock, reset, req_xfer && req_last, !req_ready)
   `TLR_ASSERT_NEXT(a_keep_loading, clock, reset, req_xfer && !req_last, req_ready)
   `TLR_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind rtl_text_line_reorder tlr_checker u_tlr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_last  (req_bus.in_last),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_byte  (rsp_bus.out_byte),
   .rsp_last  (rsp_bus.out_last),
   .rsp_trunc (rsp_bus.truncated)
);

FILE: dv/testbench.sv
// Self-checking testbench for the text line reorder block.
`timescale 1ns / 1ps

module testbench;

   // The line buffer holds this many bytes; later bytes of a line are dropped.
   localparam int unsigned LINE_CAP = tlr_pkg::MAX_LEN_DEF;
   // Clock cycles before the run is declared hung.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Cycles allowed after the last expected byte so that a stray extra byte shows up.
   localparam int unsigned DRAIN_CYCLES = 24;
   // Length of the deliberate receiver hold-off, in cycles.
   localparam int unsigned HOLD_CYCLES = 300;
   // Random stimulus stops after about this many bytes.
   localparam int unsigned RANDOM_BYTES = 150;

   // One byte of a reordered line as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       truncated;
   } line_beat_type;

   // The scoreboard keeps its own copy of the line buffer. When the final byte of a
   // line is accepted, it reverses the token order of the stored line and queues the
   // bytes that the block must emit, in order.
   class line_scoreboard_type;
      logic [7:0]    line_bytes[LINE_CAP];
      int unsigned   stored;
      logic          dropped;
      line_beat_type pending[$];
      int unsigned   mismatches;

      function new();
         stored = 0;
         dropped = 1'b0;
         mismatches = 0;
      endfunction

      // Letters and digits form words; a lead byte pairs with the next; others stand alone.
      static function logic is_word_byte(input logic [7:0] b);
         return (b >= tlr_pkg::CHR_0 && b <= tlr_pkg::CHR_9) ||
                (b >= tlr_pkg::CHR_UP_A && b <= tlr_pkg::CHR_UP_Z) ||
                (b >= tlr_pkg::CHR_LO_A && b <= tlr_pkg::CHR_LO_Z);
      endfunction

      function void note_byte(input logic [7:0] b, input logic is_last);
         logic [7:0]    staged[LINE_CAP];
         int unsigned   pos;
         int unsigned   len;
         line_beat_type beat;
         if (stored < LINE_CAP) begin
            line_bytes[stored] = b;
            stored++;
         end else begin
            dropped = 1'b1;
         end
         if (!is_last) return;
         // Walk the tokens from the front and drop each one at its mirrored place.
         pos = 0;
         while (pos < stored) begin
            if (line_bytes[pos] == tlr_pkg::HEB_LEAD && pos + 1 < stored) begin
               len = 2;
            end else if (is_word_byte(line_bytes[pos])) begin
               len = 1;
               while (pos + len < stored && is_word_byte(line_bytes[pos + len])) len++;
            end else begin
               len = 1;
            end
            for (int unsigned k = 0; k < len; k++)
               staged[stored - pos - len + k] = line_bytes[pos + k];
            pos += len;
         end
         for (int unsigned k = 0; k < stored; k++) begin
            beat.out_byte = staged[k];
            beat.out_last = (k + 1 == stored);
            beat.truncated = dropped;
            pending.push_back(beat);
         end
         stored = 0;
         dropped = 1'b0;
      endfunction

      function void check_result(input line_beat_type got);
         line_beat_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected byte %h last %b truncated %b", $time,
                        got.out_byte, got.out_last, got.truncated);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: byte exp %h got %h, last exp %b got %b, truncated exp %b got %b",
                        $time, want.out_byte, got.out_byte, want.out_last, got.out_last,
                        want.truncated, got.truncated);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tlr_req_if req_bus();
   tlr_rsp_if rsp_bus();

   rtl_text_line_reorder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   line_scoreboard_type board;

   // Idle rates in percent. The stimulus process changes them between phases.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // The stimulus asks for a receiver hold-off by bumping hold_asked; the receiver
   // process notices the difference and runs the hold-off with its own counter.
   int unsigned hold_asked;
   int unsigned hold_taken;
   int unsigned hold_left;

   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off so that the block has to stop
   // taking input while a finished line sits unsent.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_taken <= 0;
      end else if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every byte that leaves the block is checked against the oldest expectation. The
   // values are read at the edge, before any register of this edge has updated.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result('{rsp_bus.out_byte, rsp_bus.out_last, rsp_bus.truncated});
   end

   // Offer one byte, optionally after an idle gap, and return at the edge where the
   // transaction completes. Valid stays high into the next call, which either lowers it
   // for a gap or replaces the payload, so each edge sees at most one update of valid.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_byte(b, is_last);
   endtask

   // Send a prepared line; its final byte carries the last marker.
   task automatic send_fixed(input logic [7:0] text[$]);
      foreach (text[k]) send_byte(text[k], k == text.size() - 1);
   endtask

   // Pick a byte that is likely to build interesting tokens: word characters from their
   // ranges, Hebrew lead bytes, bytes 80 to BF, punctuation, and fully random bytes.
   function automatic logic [7:0] pick_text_byte();
      unique case ($urandom_range(9))
         0:       return 8'($urandom_range(tlr_pkg::CHR_0, tlr_pkg::CHR_9));
         1:       return 8'($urandom_range(tlr_pkg::CHR_UP_A, tlr_pkg::CHR_UP_Z));
         2:       return 8'($urandom_range(tlr_pkg::CHR_LO_A, tlr_pkg::CHR_LO_Z));
         3, 4:    return tlr_pkg::HEB_LEAD;
         5:       return 8'($urandom_range(8'h80, 8'hBF));
         6:       return 8'($urandom_range(8'h20, 8'h2F));
         default: return 8'($urandom_range(8'hFF));
      endcase
   endfunction

   task automatic send_random_line(input int unsigned len);
      for (int unsigned k = 0; k < len; k++) send_byte(pick_text_byte(), k + 1 == len);
   endtask

   initial begin
      logic [7:0]  text[$];
      int unsigned random_sent;
      int unsigned line_no;
      int unsigned len;

      board = new();
      reset = 1'b1;
      cycle_count = 0;
      hold_asked = 0;
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      rsp_bus.ready = 1'b0;

      // First phase: sender idles a quarter of the time, receiver stalls most of it.
      send_idle_pct = 25;
      recv_stall_pct = 80;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines. A zero byte and an all-ones byte as one-byte lines.
      text = {8'h00};
      send_fixed(text);
      text = {8'hFF};
      send_fixed(text);
      // A word run, a space, a Hebrew pair, a lead byte pairing with another lead byte,
      // a lead byte pairing with a zero byte, and a trailing word.
      text = {tlr_pkg::CHR_LO_A, tlr_pkg::CHR_UP_Z, tlr_pkg::CHR_9, 8'h20,
              tlr_pkg::HEB_LEAD, 8'h90, tlr_pkg::HEB_LEAD, tlr_pkg::HEB_LEAD,
              tlr_pkg::HEB_LEAD, 8'h00, tlr_pkg::CHR_LO_Z};
      send_fixed(text);
      // A lead byte with no partner at the end of the line, then a line of just that.
      text = {8'h71, tlr_pkg::HEB_LEAD};
      send_fixed(text);
      text = {tlr_pkg::HEB_LEAD};
      send_fixed(text);
      // Every edge of the letter and digit ranges next to its non-word neighbor.
      text = {8'h2F, tlr_pkg::CHR_0, tlr_pkg::CHR_9, 8'h3A, 8'h40, tlr_pkg::CHR_UP_A,
              tlr_pkg::CHR_UP_Z, 8'h5B, 8'h60, tlr_pkg::CHR_LO_A, tlr_pkg::CHR_LO_Z,
              8'h7B};
      send_fixed(text);

      // Random lines. Most are short; an exactly full line and an overflowing line are
      // forced early, and rare long lines land near the buffer size, some with dropped bytes.
      random_sent = 0;
      line_no = 0;
      while (random_sent < RANDOM_BYTES) begin
         if (line_no == 0)
            len = LINE_CAP;
         else if (line_no == 3)
            len = $urandom_range(LINE_CAP + 1, LINE_CAP + 8);
         else if ($urandom_range(24) == 0)
            len = $urandom_range(LINE_CAP - 4, LINE_CAP + 6);
         else
            len = $urandom_range(1, 12);
         send_random_line(len);
         random_sent += len;
         line_no++;
         if (random_sent >= RANDOM_BYTES / 3 && send_idle_pct == 25) begin
            // Second phase: the roles of the two sides swap.
            send_idle_pct = 80;
            recv_stall_pct = 25;
         end else if (random_sent >= 2 * RANDOM_BYTES / 3 && send_idle_pct == 80) begin
            // Last phase: both sides run flat out, starting with a long receiver
            // hold-off while the sender keeps pushing lines.
            send_idle_pct = 0;
            recv_stall_pct = 0;
            hold_asked++;
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for every expected byte, then a little longer for any extra one.
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: rtl_text_line_reorder.f
+incdir+rtl
rtl/tlr_pkg.sv
rtl/tlr_req_if.sv
rtl/tlr_rsp_if.sv
rtl/tlr_ram.sv
rtl/tlr_ctrl.sv
rtl/tlr_dp.sv
rtl/rtl_text_line_reorder.sv
rtl/tlr_checker.sv
dv/testbench.sv
